>>> rtl/core/pmra_pkg.sv
// Package for the pedestal mean/RMS accumulator.
// Holds the queue entry type, the cell record, the back-end state codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package pmra_pkg;

    // Widest flat cell index over the full parameter range (8*8*16*8*16*64 cells)
    localparam int JOB_IDX_W = 23;
    localparam int CNT_W     = 32;
    localparam int SUM_W     = 44;
    localparam int SQ_W      = 56;
    localparam int CELL_W    = CNT_W + SUM_W + SQ_W;

    localparam logic [11:0]      ADC_MAX   = 12'd4095;
    localparam logic [CNT_W-1:0] COUNT_MAX = 32'hFFFF_FFFF;

    // Command codes
    localparam logic CMD_ACC  = 1'b0;
    localparam logic CMD_READ = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_LOW  = 2'd0;
    localparam logic [1:0] REG_HIGH = 2'd1;

    // One entry of the front-to-back queue
    typedef struct packed {
        logic                 is_read;
        logic                 in_range;
        logic [JOB_IDX_W-1:0] idx;
        logic [11:0]          adc;
        logic [23:0]          adc_sq;
    } t_job;

    // One word of the statistics store
    typedef struct packed {
        logic [CNT_W-1:0] count;
        logic [SUM_W-1:0] sum;
        logic [SQ_W-1:0]  sq;
    } t_cell;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_MUL_A,
        ST_MUL_B,
        ST_MUL_C,
        ST_DIV_M,
        ST_DIV_R,
        ST_DIV_V,
        ST_SQRT,
        ST_OUT
    } t_state;

endpackage

>>> rtl/core/pedestal_mean_rms_accumulator.sv
// Top level of the pedestal mean/RMS accumulator.
// Depends on pmra_pkg, pmra_front, pmra_fifo, pmra_back, pmra_ram.
`timescale 1ns / 1ps
// After reset the store is swept to zero, one cell per cycle, over all
// MODULES*ASICS*CHANNELS*ROWS*COLUMNS*SAMPLES cells (65536 at the defaults);
// no item is accepted during the sweep, configuration writes are. Items pass
// a 4-entry queue to the back end, which handles one at a time against the
// single store: an accumulate reads the cell and then writes it back, a
// sample outside the limits is dropped at the input and never reaches the
// back end, a readout of an empty or out-of-range cell goes from fetch and
// read straight to output load, and a readout of a filled cell runs three
// 44-step shift-add multiplies, three 96-step restoring divides and a 32-step
// square root between read and output load. The result is held in an output
// register so the next item proceeds meanwhile.
module pedestal_mean_rms_accumulator
    import pmra_pkg::*;
#(
    parameter int MODULES  = 2,
    parameter int ASICS    = 4,
    parameter int CHANNELS = 8,
    parameter int ROWS     = 4,
    parameter int COLUMNS  = 8,
    parameter int SAMPLES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_module_index,
    input  logic [1:0]  i_asic_index,
    input  logic [2:0]  i_channel,
    input  logic [1:0]  i_row,
    input  logic [2:0]  i_column,
    input  logic [4:0]  i_sample_slot,
    input  logic [11:0] i_adc,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_entries,
    output logic        o_has_entries,
    output logic [15:0] o_mean_q4,
    output logic [11:0] o_mean_rounded,
    output logic [14:0] o_rms_q4,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data
);

    logic clear_done;
    logic full;
    logic empty;
    logic push;
    logic pop;
    t_job front_job;
    t_job queue_job;

    assign o_cfg_ready = 1'b1;

    pmra_front #(
        .MODULES(MODULES), .ASICS(ASICS), .CHANNELS(CHANNELS),
        .ROWS(ROWS), .COLUMNS(COLUMNS), .SAMPLES(SAMPLES)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_cmd         (i_cmd),
        .i_module_index(i_module_index),
        .i_asic_index  (i_asic_index),
        .i_channel     (i_channel),
        .i_row         (i_row),
        .i_column      (i_column),
        .i_sample_slot (i_sample_slot),
        .i_adc         (i_adc),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_clear_done  (clear_done),
        .i_full        (full),
        .o_push        (push),
        .o_job         (front_job)
    );

    pmra_fifo u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (push),
        .i_job  (front_job),
        .i_pop  (pop),
        .o_job  (queue_job),
        .o_full (full),
        .o_empty(empty)
    );

    pmra_back #(
        .MODULES(MODULES), .ASICS(ASICS), .CHANNELS(CHANNELS),
        .ROWS(ROWS), .COLUMNS(COLUMNS), .SAMPLES(SAMPLES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (empty),
        .i_job         (queue_job),
        .o_pop         (pop),
        .o_clear_done  (clear_done),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_entries     (o_entries),
        .o_has_entries (o_has_entries),
        .o_mean_q4     (o_mean_q4),
        .o_mean_rounded(o_mean_rounded),
        .o_rms_q4      (o_rms_q4)
    );

endmodule

>>> rtl/core/pmra_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module pmra_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> rtl/core/pmra_front.sv
// Front end: configuration registers, address range check, limit check and
// flat cell index. Depends on pmra_pkg.
`timescale 1ns / 1ps
module pmra_front
    import pmra_pkg::*;
#(
    parameter int MODULES  = 2,
    parameter int ASICS    = 4,
    parameter int CHANNELS = 8,
    parameter int ROWS     = 4,
    parameter int COLUMNS  = 8,
    parameter int SAMPLES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_cmd,
    input  logic        i_module_index,
    input  logic [1:0]  i_asic_index,
    input  logic [2:0]  i_channel,
    input  logic [1:0]  i_row,
    input  logic [2:0]  i_column,
    input  logic [4:0]  i_sample_slot,
    input  logic [11:0] i_adc,
    input  logic        i_cfg_valid,
    input  logic [1:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    input  logic        i_clear_done,
    input  logic        i_full,
    output logic        o_push,
    output t_job        o_job
);

    logic [11:0]          r_low;
    logic [11:0]          r_high;
    logic                 in_range;
    logic                 keep;
    logic [JOB_IDX_W-1:0] idx_a;
    logic [JOB_IDX_W-1:0] idx_c;
    logic [JOB_IDX_W-1:0] idx_r;
    logic [JOB_IDX_W-1:0] idx_col;
    logic [JOB_IDX_W-1:0] idx_s;

    // Limit registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_low  <= 12'd0;
            r_high <= ADC_MAX;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_LOW) begin
                r_low <= i_cfg_data;
            end else if (i_cfg_index == REG_HIGH) begin
                r_high <= i_cfg_data;
            end
        end
    end

    // Address check and mixed-radix cell index
    always_comb begin
        in_range = (32'(i_module_index) < MODULES) && (32'(i_asic_index) < ASICS) &&
                   (32'(i_channel) < CHANNELS) && (32'(i_row) < ROWS) &&
                   (32'(i_column) < COLUMNS) && (32'(i_sample_slot) < SAMPLES);
        idx_a   = JOB_IDX_W'(32'(i_module_index) * ASICS) + JOB_IDX_W'(i_asic_index);
        idx_c   = JOB_IDX_W'(32'(idx_a) * CHANNELS) + JOB_IDX_W'(i_channel);
        idx_r   = JOB_IDX_W'(32'(idx_c) * ROWS) + JOB_IDX_W'(i_row);
        idx_col = JOB_IDX_W'(32'(idx_r) * COLUMNS) + JOB_IDX_W'(i_column);
        idx_s   = JOB_IDX_W'(32'(idx_col) * SAMPLES) + JOB_IDX_W'(i_sample_slot);
        // samples outside the window never reach the queue
        keep = (i_cmd == CMD_READ) ||
               (in_range && (i_adc > r_low) && (i_adc < r_high));
    end

    assign o_in_ready      = i_clear_done && !i_full;
    assign o_push          = i_in_valid && o_in_ready && keep;
    assign o_job.is_read   = (i_cmd == CMD_READ);
    assign o_job.in_range  = in_range;
    assign o_job.idx       = in_range ? idx_s : '0;
    assign o_job.adc       = i_adc;
    assign o_job.adc_sq    = 24'(i_adc) * 24'(i_adc);

endmodule

>>> rtl/core/pmra_fifo.sv
// Short queue between front and back end (4 entries).
// Depends on pmra_pkg.
`timescale 1ns / 1ps
module pmra_fifo
    import pmra_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_job i_job,
    input  logic i_pop,
    output t_job o_job,
    output logic o_full,
    output logic o_empty
);

    t_job       r_mem [4];
    logic [1:0] r_wr_ptr;
    logic [1:0] r_rd_ptr;
    logic [2:0] r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 2'd0;
            r_rd_ptr <= 2'd0;
            r_count  <= 3'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 2'd1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 2'd1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 3'd1;
            end else if (!i_push && i_pop) begin
                r_count <= r_count - 3'd1;
            end
        end
    end

    assign o_job   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == 3'd4);
    assign o_empty = (r_count == 3'd0);

endmodule

>>> rtl/core/pmra_back.sv
// Back end: statistics store, clearing pass, read-modify-write of a cell and
// the sequenced readout math (shift-add multiply, restoring divide, bitwise
// square root). Depends on pmra_pkg and pmra_ram.
`timescale 1ns / 1ps
module pmra_back
    import pmra_pkg::*;
#(
    parameter int MODULES  = 2,
    parameter int ASICS    = 4,
    parameter int CHANNELS = 8,
    parameter int ROWS     = 4,
    parameter int COLUMNS  = 8,
    parameter int SAMPLES  = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_empty,
    input  t_job        i_job,
    output logic        o_pop,
    output logic        o_clear_done,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [31:0] o_entries,
    output logic        o_has_entries,
    output logic [15:0] o_mean_q4,
    output logic [11:0] o_mean_rounded,
    output logic [14:0] o_rms_q4
);

    localparam int CELLS  = MODULES * ASICS * CHANNELS * ROWS * COLUMNS * SAMPLES;
    localparam int ADDR_W = (CELLS > 1) ? $clog2(CELLS) : 1;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(CELLS - 1);
    localparam logic [6:0] MUL_STEPS  = 7'd44;
    localparam logic [6:0] DIV_STEPS  = 7'd96;
    localparam logic [6:0] SQRT_STEPS = 7'd32;

    t_state            r_state;
    t_state            n_state;
    logic [ADDR_W-1:0] r_clr_addr;
    t_job              r_job;

    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    t_cell             wr_cell;
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic [CELL_W-1:0] rd_data;
    t_cell             rd_cell;

    logic [31:0] r_n;
    logic [43:0] r_sum;
    logic        r_has;
    logic [87:0] r_ma;
    logic [43:0] r_mb;
    logic [87:0] r_acc;
    logic [87:0] r_d;
    logic [95:0] r_dnum;
    logic [63:0] r_dden;
    logic [63:0] r_rem;
    logic [63:0] r_quo;
    logic [63:0] r_sx;
    logic [63:0] r_sres;
    logic [63:0] r_sbit;
    logic [6:0]  r_cnt;
    logic [15:0] r_mq4;
    logic [11:0] r_mr;
    logic [14:0] r_rms;

    logic        r_o_valid;
    logic [31:0] r_o_entries;
    logic        r_o_has;
    logic [15:0] r_o_mq4;
    logic [11:0] r_o_mr;
    logic [14:0] r_o_rms;

    logic [87:0] n_acc;
    logic [64:0] rem2;
    logic [64:0] rem_sub;
    logic        div_ge;
    logic [63:0] n_rem;
    logic [63:0] n_quo;
    logic [63:0] trial;
    logic        sq_ge;
    logic [63:0] n_sres;
    logic        last;
    logic        load_out;

    assign rd_cell = t_cell'(rd_data);

    pmra_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS),
        .ADDR_W(ADDR_W)
    ) u_store (
        .i_clk    (i_clk),
        .i_wr_en  (wr_en),
        .i_wr_addr(wr_addr),
        .i_wr_data(wr_cell),
        .i_rd_en  (rd_en),
        .i_rd_addr(rd_addr),
        .o_rd_data(rd_data)
    );

    // One step of the shared multiply unit, the shared divide unit and the square root
    always_comb begin
        n_acc   = r_mb[0] ? (r_acc + r_ma) : r_acc;
        rem2    = {r_rem, r_dnum[95]};
        rem_sub = rem2 - {1'b0, r_dden};
        div_ge  = (rem2 >= {1'b0, r_dden});
        n_rem   = div_ge ? rem_sub[63:0] : rem2[63:0];
        n_quo   = {r_quo[62:0], div_ge};
        trial   = r_sres + r_sbit;
        sq_ge   = (r_sx >= trial);
        n_sres  = sq_ge ? ((r_sres >> 1) + r_sbit) : (r_sres >> 1);
        last    = (r_cnt == 7'd1);
    end

    // State register and clearing address
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_CLEAR;
            r_clr_addr <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) begin
                r_clr_addr <= r_clr_addr + ADDR_W'(1);
            end
        end
    end

    // Next state, store access and queue pop
    always_comb begin
        n_state  = r_state;
        wr_en    = 1'b0;
        wr_addr  = r_job.idx[ADDR_W-1:0];
        wr_cell  = '0;
        rd_en    = 1'b0;
        rd_addr  = i_job.idx[ADDR_W-1:0];
        o_pop    = 1'b0;
        load_out = 1'b0;
        case (r_state)
            ST_CLEAR: begin
                wr_en   = 1'b1;
                wr_addr = r_clr_addr;
                if (r_clr_addr == LAST_ADDR) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    o_pop   = 1'b1;
                    rd_en   = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (!r_job.is_read) begin
                    // accumulate: write back unless the count is saturated
                    wr_en         = (rd_cell.count != COUNT_MAX);
                    wr_cell.count = rd_cell.count + 32'd1;
                    wr_cell.sum   = rd_cell.sum + 44'(r_job.adc);
                    wr_cell.sq    = rd_cell.sq + 56'(r_job.adc_sq);
                    n_state       = ST_IDLE;
                end else if (!r_job.in_range || rd_cell.count == '0) begin
                    n_state = ST_OUT;
                end else begin
                    n_state = ST_MUL_A;
                end
            end
            ST_MUL_A: if (last) n_state = ST_MUL_B;
            ST_MUL_B: if (last) n_state = ST_MUL_C;
            ST_MUL_C: if (last) n_state = ST_DIV_M;
            ST_DIV_M: if (last) n_state = ST_DIV_R;
            ST_DIV_R: if (last) n_state = ST_DIV_V;
            ST_DIV_V: if (last) n_state = ST_SQRT;
            ST_SQRT:  if (last) n_state = ST_OUT;
            ST_OUT: begin
                if (!r_o_valid || i_out_ready) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Readout datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            ST_IDLE: begin
                if (!i_empty) begin
                    r_job <= i_job;
                end
            end
            ST_READ: begin
                r_n   <= rd_cell.count;
                r_sum <= rd_cell.sum;
                r_has <= r_job.in_range && (rd_cell.count != '0);
                r_ma  <= 88'(rd_cell.sq);
                r_mb  <= 44'(rd_cell.count);
                r_acc <= '0;
                r_cnt <= MUL_STEPS;
                r_mq4 <= '0;
                r_mr  <= '0;
                r_rms <= '0;
            end
            ST_MUL_A, ST_MUL_B, ST_MUL_C: begin
                r_acc <= n_acc;
                r_ma  <= r_ma << 1;
                r_mb  <= r_mb >> 1;
                r_cnt <= r_cnt - 7'd1;
                if (last) begin
                    r_cnt <= MUL_STEPS;
                    if (r_state == ST_MUL_A) begin
                        // n * sum of squares
                        r_d   <= n_acc;
                        r_ma  <= 88'(r_sum);
                        r_mb  <= r_sum;
                        r_acc <= '0;
                    end else if (r_state == ST_MUL_B) begin
                        // minus sum squared
                        r_d   <= r_d - n_acc;
                        r_ma  <= 88'(r_n);
                        r_mb  <= 44'(r_n);
                        r_acc <= '0;
                    end else begin
                        // n squared stays in the accumulator; start mean in Q4
                        r_dnum <= 96'({r_sum, 4'b0000} + 48'(r_n >> 1));
                        r_dden <= 64'(r_n);
                        r_rem  <= '0;
                        r_quo  <= '0;
                        r_cnt  <= DIV_STEPS;
                    end
                end
            end
            ST_DIV_M, ST_DIV_R, ST_DIV_V: begin
                r_rem  <= n_rem;
                r_quo  <= n_quo;
                r_dnum <= r_dnum << 1;
                r_cnt  <= r_cnt - 7'd1;
                if (last) begin
                    r_rem <= '0;
                    r_quo <= '0;
                    r_cnt <= DIV_STEPS;
                    if (r_state == ST_DIV_M) begin
                        r_mq4  <= (n_quo > 64'd65535) ? 16'hFFFF : n_quo[15:0];
                        r_dnum <= 96'({2'b00, r_sum, 1'b0} + 47'(r_n));
                        r_dden <= 64'({r_n, 1'b0});
                    end else if (r_state == ST_DIV_R) begin
                        r_mr   <= (n_quo > 64'(ADC_MAX)) ? ADC_MAX : n_quo[11:0];
                        r_dnum <= {r_d, 8'h00};
                        r_dden <= r_acc[63:0];
                    end else begin
                        // variance in Q8 goes to the square root
                        r_sx   <= n_quo;
                        r_sres <= '0;
                        r_sbit <= 64'h4000_0000_0000_0000;
                        r_cnt  <= SQRT_STEPS;
                    end
                end
            end
            ST_SQRT: begin
                if (sq_ge) begin
                    r_sx <= r_sx - trial;
                end
                r_sres <= n_sres;
                r_sbit <= r_sbit >> 2;
                r_cnt  <= r_cnt - 7'd1;
                if (last) begin
                    r_rms <= (n_sres > 64'd32767) ? 15'h7FFF : n_sres[14:0];
                end
            end
            default: begin
            end
        endcase
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (load_out) begin
            r_o_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load_out) begin
            r_o_entries <= r_has ? r_n : 32'd0;
            r_o_has     <= r_has;
            r_o_mq4     <= r_mq4;
            r_o_mr      <= r_mr;
            r_o_rms     <= r_rms;
        end
    end

    assign o_clear_done   = (r_state != ST_CLEAR);
    assign o_out_valid    = r_o_valid;
    assign o_entries      = r_o_entries;
    assign o_has_entries  = r_o_has;
    assign o_mean_q4      = r_o_mq4;
    assign o_mean_rounded = r_o_mr;
    assign o_rms_q4       = r_o_rms;

endmodule

>>> rtl/core/pmra_checker.sv
// Port-level checks for the pedestal mean/RMS accumulator, bound to the top level.
// Depends on pedestal_mean_rms_accumulator.
`timescale 1ns / 1ps
module pmra_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_in_ready,
    input logic        o_out_valid,
    input logic        i_out_ready,
    input logic [31:0] o_entries,
    input logic        o_has_entries,
    input logic [15:0] o_mean_q4,
    input logic [11:0] o_mean_rounded,
    input logic [14:0] o_rms_q4
);

    // Clearing pass follows every reset
    a_clear_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_in_ready)
        else $error("input ready right after reset");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_entries) &&
        $stable(o_mean_q4) && $stable(o_rms_q4))
        else $error("result changed while stalled");

    // Flag agrees with the count
    a_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_has_entries == (o_entries != 32'd0)))
        else $error("has_entries disagrees with entries");

    // Empty cell reports zero statistics
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_has_entries |->
        (o_mean_q4 == 16'd0) && (o_mean_rounded == 12'd0) && (o_rms_q4 == 15'd0))
        else $error("empty cell with nonzero statistics");

endmodule

bind pedestal_mean_rms_accumulator pmra_checker u_pmra_checker (.*);
